>>> rtl/core/mmd_pkg.sv
// Package: default generics, shared widths, register indexes, reset values and divider handshake types.
package mmd_pkg;

    // Default generics
    localparam int MAX_DIM_DEF       = 16;
    localparam int ELEMENT_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int DIM_W = 5;
    localparam int MOD_W = 8;
    localparam int DVD_W = 2 * MOD_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // Register index width and codes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'd1;

    // Reset values of the registers
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd3;
    localparam logic [MOD_W-1:0] MOD_RESET = 8'd3;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [MOD_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> rtl/core/mmd_in_if.sv
// Interface: element input channel.
interface mmd_in_if #(
    parameter int ELEMENT_WIDTH = mmd_pkg::ELEMENT_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [ELEMENT_WIDTH-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

>>> rtl/core/mmd_out_if.sv
// Interface: determinant result channel.
interface mmd_out_if;
    logic                     valid;
    logic                     ready;
    logic [mmd_pkg::MOD_W-1:0] determinant;
    logic                     invertible;
    logic                     unit_determinant;

    modport source (output valid, output determinant, output invertible,
                    output unit_determinant, input ready);
    modport sink   (input valid, input determinant, input invertible,
                    input unit_determinant, output ready);
endinterface

>>> rtl/core/mmd_divider.sv
// Shared restoring divider: one quotient bit per cycle.
module mmd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmd_pkg::t_div_req i_req,
    output mmd_pkg::t_div_rsp o_rsp
);
    localparam int DW = mmd_pkg::DVD_W;
    localparam int MW = mmd_pkg::MOD_W;
    localparam int CW = mmd_pkg::CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_quo;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_div;

    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // Control: busy span and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend, build quotient, keep remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[MW-1:0] : trial[MW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;
endmodule

>>> rtl/core/mmd_engine.sv
// Sequencer: matrix load, Euclidean row elimination and determinant product.
module mmd_engine #(
    parameter int MAX_DIM       = mmd_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_WIDTH = mmd_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0] i_dim,
    input  logic [mmd_pkg::MOD_W-1:0]   i_mod,
    input  logic                        i_el_valid,
    output logic                        o_el_ready,
    input  logic [ELEMENT_WIDTH-1:0]    i_element,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [mmd_pkg::MOD_W-1:0]   o_det
);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = mmd_pkg::MOD_W;
    localparam int VW    = mmd_pkg::DVD_W;

    typedef enum logic [4:0] {
        S_LOAD, S_LDIV, S_COL, S_ROW, S_RCC, S_CHK, S_QDIV, S_J,
        S_JR1, S_JR2, S_JDIV, S_JW2, S_DRD, S_DDIV, S_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [DW-1:0] r_lr, n_lr, r_lc, n_lc;
    logic [DW-1:0] r_c, n_c, r_r, n_r, r_j, n_j;
    logic [MW-1:0] r_b, n_b, r_x, n_x, r_q, n_q, r_det, n_det;
    logic          r_neg, n_neg;

    logic [MW-1:0] mem [DEPTH];
    logic [MW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [MW-1:0] mem_wd;

    mmd_pkg::t_div_req div_req;
    mmd_pkg::t_div_rsp div_rsp;

    logic [MW:0]   sub_s;
    logic [MW-1:0] sub_r;
    logic [DW-1:0] last;

    function automatic logic [AW-1:0] addr(input logic [DW-1:0] row,
                                           input logic [DW-1:0] col);
        return AW'(32'(row) * MAX_DIM + 32'(col));
    endfunction

    mmd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Matrix memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // Row update: (a[c][j] + m - t) mod m with both operands below m
    always_comb begin
        sub_s = {1'b0, r_x} + {1'b0, i_mod} - {1'b0, div_rsp.remainder};
        sub_r = (sub_s >= {1'b0, i_mod}) ? MW'(sub_s - {1'b0, i_mod}) : sub_s[MW-1:0];
    end

    assign last        = i_dim - DW'(1);
    assign o_el_ready  = (r_state == S_LOAD);
    assign o_res_valid = (r_state == S_FIN);
    assign o_det       = (r_neg && (r_det != '0)) ? MW'(i_mod - r_det) : r_det;

    // Next-state and datapath sequencing
    always_comb begin
        n_state = r_state;
        n_lr = r_lr; n_lc = r_lc;
        n_c = r_c; n_r = r_r; n_j = r_j;
        n_b = r_b; n_x = r_x; n_q = r_q; n_det = r_det; n_neg = r_neg;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = i_mod;
        unique case (r_state)
            S_LOAD: begin
                if (i_el_valid) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = VW'(i_element);
                    n_state = S_LDIV;
                end
            end
            S_LDIV: begin
                if (div_rsp.done) begin
                    mem_we = 1'b1;
                    mem_wa = addr(r_lr, r_lc);
                    mem_wd = div_rsp.remainder;
                    n_state = S_LOAD;
                    if (r_lc == last) begin
                        n_lc = '0;
                        n_lr = r_lr + DW'(1);
                        if (r_lr == last) begin
                            n_lr = '0;
                            n_c = '0;
                            n_det = MW'(1);
                            n_neg = 1'b0;
                            n_state = S_COL;
                        end
                    end else begin
                        n_lc = r_lc + DW'(1);
                    end
                end
            end
            S_COL: begin
                if (r_c == i_dim) begin
                    n_state = S_FIN;
                end else begin
                    n_r = r_c + DW'(1);
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (r_r == i_dim) begin
                    mem_ra = addr(r_c, r_c);
                    n_state = S_DRD;
                end else begin
                    mem_ra = addr(r_r, r_c);
                    n_state = S_RCC;
                end
            end
            S_RCC: begin
                n_b = r_rdata;
                mem_ra = addr(r_c, r_c);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_b == '0) begin
                    n_r = r_r + DW'(1);
                    n_state = S_ROW;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = VW'(r_rdata);
                    div_req.divisor  = r_b;
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                if (div_rsp.done) begin
                    n_q = div_rsp.quotient[MW-1:0];
                    n_j = r_c;
                    n_state = S_J;
                end
            end
            S_J: begin
                if (r_j == i_dim) begin
                    n_neg = !r_neg;
                    mem_ra = addr(r_r, r_c);
                    n_state = S_RCC;
                end else begin
                    mem_ra = addr(r_c, r_j);
                    n_state = S_JR1;
                end
            end
            S_JR1: begin
                n_x = r_rdata;
                mem_ra = addr(r_r, r_j);
                n_state = S_JR2;
            end
            S_JR2: begin
                n_b = r_rdata;
                div_req.start    = 1'b1;
                div_req.dividend = r_q * r_rdata;
                n_state = S_JDIV;
            end
            S_JDIV: begin
                if (div_rsp.done) begin
                    mem_we = 1'b1;
                    mem_wa = addr(r_c, r_j);
                    mem_wd = r_b;
                    n_x = sub_r;
                    n_state = S_JW2;
                end
            end
            S_JW2: begin
                mem_we = 1'b1;
                mem_wa = addr(r_r, r_j);
                mem_wd = r_x;
                n_j = r_j + DW'(1);
                n_state = S_J;
            end
            S_DRD: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_det * r_rdata;
                n_state = S_DDIV;
            end
            S_DDIV: begin
                if (div_rsp.done) begin
                    n_det = div_rsp.remainder;
                    n_c = r_c + DW'(1);
                    n_state = S_COL;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Hold state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_lr    <= '0;
            r_lc    <= '0;
        end else begin
            r_state <= n_state;
            r_lr    <= n_lr;
            r_lc    <= n_lc;
        end
        r_c   <= n_c;
        r_r   <= n_r;
        r_j   <= n_j;
        r_b   <= n_b;
        r_x   <= n_x;
        r_q   <= n_q;
        r_det <= n_det;
        r_neg <= n_neg;
    end
endmodule

>>> rtl/core/modular_matrix_determinant.sv
// Top level: configuration registers, element sequencer and result register.
//
//  channel     dir  transfer when      payload
//  i_elem_ch   in   valid && ready     element
//  o_res_ch    out  valid && ready     determinant, invertible, unit_determinant
//  i_cfg_*     in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// Each element is reduced modulo the modulus on the divider before the next one is taken.
// After the last element, elimination runs on the shared divider: a Euclidean
// row swap divides once for its quotient and once per column it touches, a zero
// test reads the entry, and each diagonal product takes one division.
// Synchronous active-low reset returns to loading; the memory needs no clear.
// A pending result stalls the final handoff, and with it the next load.
module modular_matrix_determinant #(
    parameter int MAX_DIM       = mmd_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_WIDTH = mmd_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mmd_in_if.sink                            i_elem_ch,
    mmd_out_if.source                         o_res_ch,
    input  logic                              i_cfg_we,
    input  logic [mmd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmd_pkg::MOD_W-1:0]         i_cfg_data
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int MW = mmd_pkg::MOD_W;

    logic [mmd_pkg::DIM_W-1:0] r_dim;
    logic [MW-1:0]             r_mod;
    logic [DW-1:0]             eff_dim;
    logic [MW-1:0]             eff_mod;

    logic          res_valid;
    logic          res_ready;
    logic [MW-1:0] res_det;

    logic          r_out_valid;
    logic [MW-1:0] r_out_det;
    logic          r_out_inv;
    logic          r_out_unit;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= mmd_pkg::DIM_RESET;
            r_mod <= mmd_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mmd_pkg::CFG_DIMENSION: r_dim <= i_cfg_data[mmd_pkg::DIM_W-1:0];
                mmd_pkg::CFG_MODULUS:   r_mod <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimension and modulus into their working range
    always_comb begin
        if (r_dim == '0) begin
            eff_dim = DW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            eff_dim = DW'(MAX_DIM);
        end else begin
            eff_dim = DW'(r_dim);
        end
        eff_mod = (r_mod < MW'(2)) ? MW'(2) : r_mod;
    end

    mmd_engine #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dim       (eff_dim),
        .i_mod       (eff_mod),
        .i_el_valid  (i_elem_ch.valid),
        .o_el_ready  (i_elem_ch.ready),
        .i_element   (i_elem_ch.element),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_det       (res_det)
    );

    assign res_ready = !r_out_valid || o_res_ch.ready;

    // Result register: load on handoff, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_det  <= res_det;
            r_out_inv  <= (res_det != '0);
            r_out_unit <= (res_det == MW'(1));
        end
    end

    assign o_res_ch.valid            = r_out_valid;
    assign o_res_ch.determinant      = r_out_det;
    assign o_res_ch.invertible       = r_out_inv;
    assign o_res_ch.unit_determinant = r_out_unit;
endmodule

>>> rtl/core/mmd_checker.sv
// Checker: port-level properties of the determinant block, bound to the top.
module mmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_det,
    input logic       i_inv,
    input logic       i_unit
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_det))
        else $error("result dropped or changed while stalled");

    // Invertible flag tracks a nonzero determinant
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_inv == (i_det != 8'd0)))
        else $error("invertible flag mismatch");

    // Unit flag only for determinant one
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_unit == (i_det == 8'd1)))
        else $error("unit determinant flag mismatch");

    // Busy reducing right after an element transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("element taken while reducing the previous one");
endmodule

bind modular_matrix_determinant mmd_checker u_mmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_elem_ch.valid),
    .i_in_ready  (i_elem_ch.ready),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_det       (o_res_ch.determinant),
    .i_inv       (o_res_ch.invertible),
    .i_unit      (o_res_ch.unit_determinant)
);
